// ===== src/hme_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package hme_pkg;
   localparam int BUCKETS    = 256;
   localparam int WAYS       = 4;
   localparam int KEY_BITS   = 32;
   localparam int VALUE_BITS = 32;
   localparam int SLOTS      = BUCKETS * WAYS;
   localparam int SLOT_BITS  = $clog2(SLOTS);
   localparam int BKT_BITS   = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int WAY_BITS   = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int CFG_BITS   = 9;
   localparam int CNT_BITS   = 11;
   localparam int KCNT_BITS  = $clog2(KEY_BITS + 1);
   localparam int WCNT_BITS  = $clog2(WAYS + 1);

   localparam logic [1:0] MODE_INSERT = 2'd0;
   localparam logic [1:0] MODE_LOOKUP = 2'd1;
   localparam logic [1:0] MODE_REMOVE = 2'd2;
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   localparam logic [2:0] ST_INSERTED = 3'd0;
   localparam logic [2:0] ST_PRESENT  = 3'd1;
   localparam logic [2:0] ST_FULL     = 3'd2;
   localparam logic [2:0] ST_FOUND    = 3'd3;
   localparam logic [2:0] ST_MISSING  = 3'd4;
   localparam logic [2:0] ST_REMOVED  = 3'd5;

   typedef enum logic [2:0] {
      S_CLR, S_IDLE, S_DIV, S_SCAN, S_WAIT, S_ACT, S_OUT
   } state_type;

   typedef struct packed {
      logic clr_step;
      logic load;
      logic div_step;
      logic scan_start;
      logic scan_step;
      logic act;
   } cmd_type;

   typedef struct packed {
      logic clr_done;
      logic div_done;
      logic scan_done;
   } sts_type;
endpackage
`default_nettype wire

// ===== src/hme_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module hme_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   input  wire hme_pkg::sts_type sts,
   output hme_pkg::cmd_type      cmd
);
   hme_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= hme_pkg::S_CLR;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         hme_pkg::S_CLR:  if (sts.clr_done) state_in = hme_pkg::S_IDLE;
         hme_pkg::S_IDLE: if (req_valid) state_in = hme_pkg::S_DIV;
         hme_pkg::S_DIV:  if (sts.div_done) state_in = hme_pkg::S_SCAN;
         hme_pkg::S_SCAN: state_in = hme_pkg::S_WAIT;
         hme_pkg::S_WAIT: if (sts.scan_done) state_in = hme_pkg::S_ACT;
         hme_pkg::S_ACT:  state_in = hme_pkg::S_OUT;
         hme_pkg::S_OUT:  if (rsp_ready) state_in = hme_pkg::S_IDLE;
         default:         state_in = hme_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         hme_pkg::S_CLR:  cmd.clr_step = 1'b1;
         hme_pkg::S_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         hme_pkg::S_DIV:  cmd.div_step   = 1'b1;
         hme_pkg::S_SCAN: cmd.scan_start = 1'b1;
         hme_pkg::S_WAIT: cmd.scan_step  = 1'b1;
         hme_pkg::S_ACT:  cmd.act        = 1'b1;
         hme_pkg::S_OUT:  rsp_valid      = 1'b1;
         default: ;
      endcase
   end
endmodule
`default_nettype wire

// ===== src/hme_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
module hme_dp (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire hme_pkg::cmd_type                   cmd,
   output hme_pkg::sts_type                        sts,
   input  wire logic [1:0]                         req_mode,
   input  wire logic [31:0]                        req_key,
   input  wire logic [31:0]                        req_value,
   input  wire logic                               csr_valid,
   input  wire logic [hme_pkg::CFG_BITS-1:0]       csr_data,
   output logic [2:0]                              rsp_status,
   output logic                                    rsp_found,
   output logic [31:0]                             rsp_read_value,
   output logic [10:0]                             rsp_entry_total
);
   localparam int KB = hme_pkg::KEY_BITS;
   localparam int VB = hme_pkg::VALUE_BITS;
   localparam int SB = hme_pkg::SLOT_BITS;
   localparam int WB = hme_pkg::WAY_BITS;

   logic [hme_pkg::CFG_BITS-1:0] bcnt_ff;
   logic [1:0]                   mode_ff;
   logic [KB-1:0]                key_ff, quo_ff;
   logic [VB-1:0]                val_ff;
   logic [hme_pkg::CFG_BITS-1:0] div_ff, rem_ff;
   logic [hme_pkg::KCNT_BITS-1:0] kcnt_ff;
   logic [hme_pkg::BKT_BITS-1:0] bkt_ff;
   logic [hme_pkg::WCNT_BITS-1:0] wcnt_ff;
   logic [WB-1:0]                rway_ff;
   logic                         rd_pend_ff;
   logic                         hit_ff, free_ff;
   logic [WB-1:0]                hway_ff, fway_ff;
   logic [VB-1:0]                hval_ff;
   logic [hme_pkg::WAYS-1:0]     vld_mem [hme_pkg::BUCKETS];
   logic [hme_pkg::WAYS-1:0]     vrow_ff, vrow_wr;
   logic [hme_pkg::BKT_BITS-1:0] clr_ff;
   logic [KB-1:0]                key_mem [hme_pkg::SLOTS];
   logic [VB-1:0]                val_mem [hme_pkg::SLOTS];
   logic [KB-1:0]                rkey_ff;
   logic [VB-1:0]                rval_ff;
   logic [hme_pkg::CNT_BITS-1:0] count_ff;
   logic [2:0]                   status_ff;
   logic                         found_ff;
   logic [31:0]                  rdv_ff;

   logic [hme_pkg::CFG_BITS:0]   trial;
   logic [hme_pkg::CFG_BITS-1:0] rem_sh;
   logic [SB-1:0]                raddr, fslot;
   logic [hme_pkg::CFG_BITS-1:0] eff;
   logic                         ins_ok, rem_ok, vld_we;

   always_comb begin
      eff = bcnt_ff;
      if (bcnt_ff == '0) eff = hme_pkg::CFG_BITS'(1);
      if (32'(bcnt_ff) > 32'(hme_pkg::BUCKETS)) eff = hme_pkg::CFG_BITS'(hme_pkg::BUCKETS);
   end

   assign rem_sh = {rem_ff[hme_pkg::CFG_BITS-2:0], quo_ff[KB-1]};
   assign trial  = {rem_ff[hme_pkg::CFG_BITS-1], rem_sh} - {1'b0, div_ff};
   assign raddr  = SB'(32'(bkt_ff) * hme_pkg::WAYS + 32'(wcnt_ff));
   assign fslot  = SB'(32'(bkt_ff) * hme_pkg::WAYS + 32'(fway_ff));
   assign sts.clr_done  = (clr_ff == hme_pkg::BKT_BITS'(hme_pkg::BUCKETS - 1));
   assign sts.div_done  = (kcnt_ff == hme_pkg::KCNT_BITS'(KB - 1));
   assign sts.scan_done = !rd_pend_ff && (wcnt_ff == hme_pkg::WCNT_BITS'(hme_pkg::WAYS));

   assign ins_ok = (mode_ff == hme_pkg::MODE_INSERT) && !hit_ff && free_ff;
   assign rem_ok = (mode_ff == hme_pkg::MODE_REMOVE) && hit_ff;
   assign vld_we = cmd.act && (ins_ok || rem_ok);

   always_ff @(posedge clock) begin
      if (reset) bcnt_ff <= hme_pkg::CFG_BITS'(256);
      else if (csr_valid) bcnt_ff <= csr_data;
   end

   // restoring divider, one quotient bit a cycle; quotient is discarded
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff <= req_mode;
         key_ff  <= KB'(req_key);
         quo_ff  <= KB'(req_key);
         val_ff  <= VB'(req_value);
         div_ff  <= eff;
         rem_ff  <= '0;
         kcnt_ff <= '0;
      end else if (cmd.div_step) begin
         quo_ff  <= {quo_ff[KB-2:0], 1'b0};
         kcnt_ff <= kcnt_ff + 1'b1;
         if (!trial[hme_pkg::CFG_BITS]) rem_ff <= trial[hme_pkg::CFG_BITS-1:0];
         else                           rem_ff <= rem_sh;
         if (sts.div_done) begin
            if (!trial[hme_pkg::CFG_BITS]) bkt_ff <= hme_pkg::BKT_BITS'(trial);
            else                           bkt_ff <= hme_pkg::BKT_BITS'(rem_sh);
         end
      end
   end

   always_ff @(posedge clock) begin
      rkey_ff <= key_mem[raddr];
      rval_ff <= val_mem[raddr];
      if (cmd.act && ins_ok) begin
         key_mem[fslot] <= key_ff;
         val_mem[fslot] <= val_ff;
      end
   end

   // valid marks, one row of ways per bucket, cleared by a pass after reset
   always_comb begin
      vrow_wr = vrow_ff;
      if (ins_ok) vrow_wr[fway_ff] = 1'b1;
      if (rem_ok) vrow_wr[hway_ff] = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) clr_ff <= '0;
      else if (cmd.clr_step) clr_ff <= clr_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      vrow_ff <= vld_mem[bkt_ff];
      if (cmd.clr_step) vld_mem[clr_ff] <= '0;
      else if (vld_we)  vld_mem[bkt_ff] <= vrow_wr;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         wcnt_ff <= '0;
      end else if (cmd.scan_start) begin
         wcnt_ff    <= hme_pkg::WCNT_BITS'(1);
         rway_ff    <= '0;
         rd_pend_ff <= 1'b1;
         hit_ff     <= 1'b0;
         free_ff    <= 1'b0;
      end else if (cmd.scan_step && rd_pend_ff) begin
         rway_ff <= WB'(wcnt_ff);
         if (wcnt_ff == hme_pkg::WCNT_BITS'(hme_pkg::WAYS)) rd_pend_ff <= 1'b0;
         else wcnt_ff <= wcnt_ff + 1'b1;
         if (vrow_ff[rway_ff]) begin
            if (!hit_ff && rkey_ff == key_ff) begin
               hit_ff  <= 1'b1;
               hway_ff <= rway_ff;
               hval_ff <= rval_ff;
            end
         end else if (!free_ff) begin
            free_ff <= 1'b1;
            fway_ff <= rway_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.act) begin
         if (ins_ok) begin
            count_ff <= count_ff + 1'b1;
         end else if (rem_ok) begin
            if (count_ff != '0) count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.act) begin
         found_ff <= hit_ff;
         rdv_ff   <= (hit_ff && mode_ff != hme_pkg::MODE_INSERT &&
                      mode_ff != hme_pkg::MODE_REMOVE) ? 32'(hval_ff) : 32'd0;
         case (mode_ff)
            hme_pkg::MODE_INSERT:
               status_ff <= hit_ff ? hme_pkg::ST_PRESENT :
                            (free_ff ? hme_pkg::ST_INSERTED : hme_pkg::ST_FULL);
            hme_pkg::MODE_REMOVE:
               status_ff <= hit_ff ? hme_pkg::ST_REMOVED : hme_pkg::ST_MISSING;
            default:
               status_ff <= hit_ff ? hme_pkg::ST_FOUND : hme_pkg::ST_MISSING;
         endcase
      end
   end

   assign rsp_status      = status_ff;
   assign rsp_found       = found_ff;
   assign rsp_read_value  = rdv_ff;
   assign rsp_entry_total = count_ff;
endmodule
`default_nettype wire

// ===== src/hash_map_engine.sv =====
// channel | ports                                   | direction
// req     | req_valid/ready, mode, key, value       | in
// rsp     | rsp_valid/ready, status, found, ...     | out
// csr     | csr_valid/ready, csr_data               | in
// A transaction runs through the restoring modulo divider, one bit a cycle,
// then one slot read a cycle from the key/value RAM; a new request is taken
// only once the last one is done. After reset a clearing pass over all
// BUCKETS rows zeroes the valid marks, with req_ready low; the entry count
// clears at once. A stalled result holds the block until rsp_ready.
`timescale 1ns / 1ps
`default_nettype none
module hash_map_engine (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_mode,
   input  wire logic [31:0] req_key,
   input  wire logic [31:0] req_value,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [2:0]       rsp_status,
   output logic             rsp_found,
   output logic [31:0]      rsp_read_value,
   output logic [10:0]      rsp_entry_total,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [8:0]  csr_data
);
   hme_pkg::cmd_type cmd;
   hme_pkg::sts_type sts;

   assign csr_ready = 1'b1;

   hme_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .sts(sts), .cmd(cmd)
   );

   hme_dp u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts),
      .req_mode(req_mode), .req_key(req_key), .req_value(req_value),
      .csr_valid(csr_valid), .csr_data(csr_data),
      .rsp_status(rsp_status), .rsp_found(rsp_found),
      .rsp_read_value(rsp_read_value), .rsp_entry_total(rsp_entry_total)
   );

   a_one_phase: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("request and response overlap");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_entry_total))
      else $error("response changed while stalled");
   a_cmd_excl: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.clr_step, cmd.load, cmd.div_step, cmd.scan_start, cmd.scan_step,
                cmd.act}))
      else $error("overlapping datapath commands");
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_read_value == 32'd0)
      else $error("value on miss");
endmodule
`default_nettype wire

// ===== verif/hme_checker.sv =====
`timescale 1ns / 1ps
module hme_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_ready,
   input  wire logic [1:0]  req_mode,
   input  wire logic [31:0] req_key,
   input  wire logic [31:0] req_value,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_ready,
   input  wire logic [2:0]  rsp_status,
   input  wire logic        rsp_found,
   input  wire logic [31:0] rsp_read_value,
   input  wire logic [10:0] rsp_entry_total,
   input  wire logic        csr_valid,
   input  wire logic        csr_ready,
   input  wire logic [8:0]  csr_data,
   output int               fail_count,
   output int               pending,
   output int               rsp_seen
);
   typedef struct packed {
      logic [2:0]  status;
      logic        found;
      logic [31:0] read_value;
      logic [10:0] entry_total;
   } outcome_type;

   logic                           tbl_valid [hme_pkg::SLOTS];
   logic [hme_pkg::KEY_BITS-1:0]   tbl_key   [hme_pkg::SLOTS];
   logic [hme_pkg::VALUE_BITS-1:0] tbl_value [hme_pkg::SLOTS];
   logic [hme_pkg::CNT_BITS-1:0]   tbl_count;
   logic [hme_pkg::CFG_BITS-1:0]   nbuckets;
   outcome_type                    expected_q [$];

   function automatic outcome_type apply_request(logic [1:0] mode, logic [31:0] key,
                                                 logic [31:0] value);
      outcome_type o;
      int eff, base, hit;
      o = '0;
      eff = nbuckets;
      if (eff == 0) eff = 1;
      if (eff > hme_pkg::BUCKETS) eff = hme_pkg::BUCKETS;
      base = (key % eff) * hme_pkg::WAYS;
      hit = -1;
      for (int w = 0; w < hme_pkg::WAYS; w++)
         if (hit < 0 && tbl_valid[base+w] && tbl_key[base+w] == key) hit = base + w;
      if (mode == hme_pkg::MODE_INSERT) begin
         if (hit >= 0) begin
            o.status = hme_pkg::ST_PRESENT;
            o.found = 1'b1;
         end else begin
            o.status = hme_pkg::ST_FULL;
            for (int w = 0; w < hme_pkg::WAYS; w++)
               if (o.status == hme_pkg::ST_FULL && !tbl_valid[base+w]) begin
                  tbl_valid[base+w] = 1'b1;
                  tbl_key[base+w] = key;
                  tbl_value[base+w] = value;
                  tbl_count++;
                  o.status = hme_pkg::ST_INSERTED;
               end
         end
      end else if (mode == hme_pkg::MODE_REMOVE) begin
         if (hit >= 0) begin
            tbl_valid[hit] = 1'b0;
            if (tbl_count > 0) tbl_count--;
            o.status = hme_pkg::ST_REMOVED;
            o.found = 1'b1;
         end else
            o.status = hme_pkg::ST_MISSING;
      end else begin
         if (hit >= 0) begin
            o.status = hme_pkg::ST_FOUND;
            o.found = 1'b1;
            o.read_value = tbl_value[hit];
         end else
            o.status = hme_pkg::ST_MISSING;
      end
      o.entry_total = tbl_count;
      return o;
   endfunction

   assign pending = expected_q.size();

   always @(posedge clock) begin
      outcome_type got, exp_o;
      if (reset) begin
         for (int i = 0; i < hme_pkg::SLOTS; i++) tbl_valid[i] = 1'b0;
         tbl_count = '0;
         nbuckets = 9'd256;
         expected_q.delete();
         fail_count <= 0;
         rsp_seen <= 0;
      end else begin
         if (csr_valid && csr_ready) nbuckets = csr_data;
         if (req_valid && req_ready)
            expected_q.push_back(apply_request(req_mode, req_key, req_value));
         if (rsp_valid && rsp_ready) begin
            rsp_seen <= rsp_seen + 1;
            got = {rsp_status, rsp_found, rsp_read_value, rsp_entry_total};
            if (expected_q.size() == 0) begin
               $display("%0t: unexpected transaction, actual %h", $time, got);
               fail_count <= fail_count + 1;
            end else begin
               exp_o = expected_q.pop_front();
               if (got !== exp_o) begin
                  $display("%0t: mismatch expected st=%0d f=%0d v=%h n=%0d actual st=%0d f=%0d v=%h n=%0d",
                           $time, exp_o.status, exp_o.found, exp_o.read_value,
                           exp_o.entry_total, got.status, got.found, got.read_value,
                           got.entry_total);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule

// ===== verif/tb_hash_map_engine.sv =====
`timescale 1ns / 1ps
module tb_hash_map_engine;
   localparam int WATCHDOG = 20000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_mode = hme_pkg::MODE_INSERT;
   logic [31:0] req_key = '0;
   logic [31:0] req_value = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_status;
   logic        rsp_found;
   logic [31:0] rsp_read_value;
   logic [10:0] rsp_entry_total;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [8:0]  csr_data = '0;
   int          fail_count, pending, rsp_seen;
   int          idle_cycles = 0;
   int          req_sent = 0;
   bit          calm = 1'b0;
   bit          hold_rsp = 1'b0;
   logic [31:0] key_pool [16];

   always #4 clock = ~clock;

   hash_map_engine dut (.*);

   hme_checker checker_i (.*);

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // receiver: random stall bursts, or a long hold-off on request
   initial begin
      int n;
      @(negedge reset);
      forever begin
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
            for (int i = 0; i < 600; i++) @(posedge clock);
            hold_rsp = 1'b0;
         end else if (!calm && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 18);
            rsp_ready <= 1'b0;
            repeat (n) @(posedge clock);
         end else begin
            n = $urandom_range(1, 30);
            rsp_ready <= 1'b1;
            repeat (n) @(posedge clock);
         end
      end
   end

   // valid stays high after acceptance until the next transaction or a gap
   task automatic send_req(logic [1:0] mode, logic [31:0] key, logic [31:0] value);
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode  <= mode;
      req_key   <= key;
      req_value <= value;
      do @(posedge clock); while (!req_ready);
      req_sent++;
   endtask

   task automatic write_buckets(logic [8:0] n);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= n;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic random_phase(int count, logic [8:0] nb);
      logic [1:0]  m;
      logic [31:0] k;
      write_buckets(nb);
      for (int i = 0; i < 16; i++)
         key_pool[i] = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 40);
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(0, 9)) inside
            [0:3]:   m = hme_pkg::MODE_INSERT;
            [4:6]:   m = hme_pkg::MODE_LOOKUP;
            [7:8]:   m = hme_pkg::MODE_REMOVE;
            default: m = hme_pkg::MODE_UNUSED;
         endcase
         k = ($urandom_range(0, 7) == 0) ? $urandom : key_pool[$urandom_range(0, 15)];
         send_req(m, k, $urandom);
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, full bucket, duplicates, mode three
      send_req(hme_pkg::MODE_LOOKUP, 32'h0, 32'h0);
      send_req(hme_pkg::MODE_REMOVE, 32'hFFFF_FFFF, 32'h0);
      send_req(hme_pkg::MODE_INSERT, 32'h0, 32'hFFFF_FFFF);
      send_req(hme_pkg::MODE_INSERT, 32'hFFFF_FFFF, 32'h0);
      send_req(hme_pkg::MODE_INSERT, 32'h0, 32'h1234_5678);
      send_req(hme_pkg::MODE_LOOKUP, 32'h0, 32'h0);
      send_req(hme_pkg::MODE_INSERT, 32'h100, 32'hA5A5_A5A5);
      send_req(hme_pkg::MODE_INSERT, 32'h200, 32'h5A5A_5A5A);
      send_req(hme_pkg::MODE_INSERT, 32'h300, 32'h1);
      send_req(hme_pkg::MODE_INSERT, 32'h400, 32'h2);
      send_req(hme_pkg::MODE_UNUSED, 32'h300, 32'h0);
      send_req(hme_pkg::MODE_REMOVE, 32'h100, 32'h0);
      send_req(hme_pkg::MODE_INSERT, 32'h400, 32'h3);
      send_req(hme_pkg::MODE_LOOKUP, 32'h400, 32'h0);
      send_req(hme_pkg::MODE_REMOVE, 32'h100, 32'h0);
      send_req(hme_pkg::MODE_LOOKUP, 32'hFFFF_FFFF, 32'h0);
      // bucket count zero and above maximum
      write_buckets(9'd0);
      send_req(hme_pkg::MODE_INSERT, 32'h7, 32'h77);
      send_req(hme_pkg::MODE_LOOKUP, 32'h0, 32'h0);
      write_buckets(9'd511);
      send_req(hme_pkg::MODE_LOOKUP, 32'hFFFF_FFFF, 32'h0);
      send_req(hme_pkg::MODE_INSERT, 32'h1FF, 32'hDEAD_BEEF);

      // long receiver hold-off while requests keep coming
      hold_rsp = 1'b1;
      random_phase(20, 9'd256);

      random_phase(400, 9'd1);
      random_phase(400, 9'd3);
      random_phase(400, 9'd256);
      random_phase(200, 9'd17);
      calm = 1'b1;
      random_phase(200, 9'd5);

      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      $display("Sent %0d requests, %0d responses checked, bucket counts 0..511",
               req_sent, rsp_seen);
      if (fail_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end
endmodule
